[src/accumulator_cpu_execute_unit_top_defines.svh]
// Assertion macros for the accumulator machine execute unit.
// Included by the top level; assumes signals named clk and rst in scope.
`ifndef ACCUMULATOR_CPU_EXECUTE_UNIT_TOP_DEFINES_SVH
`define ACCUMULATOR_CPU_EXECUTE_UNIT_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define ACCEXU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Expression must never be true outside reset.
`define ACCEXU_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ACCEXU_ASSERT(label, prop, msg)
`define ACCEXU_ASSERT_NEVER(label, expr, msg)
`endif

`endif

[src/accexu_pkg.sv]
// Shared types and constants of the accumulator machine execute unit.
// No dependencies; used by accumulator_cpu_execute_unit_top and the testbench.
package accexu_pkg;

  localparam int DATA_WIDTH           = 32;
  localparam int REG_COUNT_DEFAULT    = 20;
  localparam int PROGRAM_DEPTH        = 256;
  localparam int PC_WIDTH             = 8;
  localparam int LEN_WIDTH            = 9;
  localparam logic [LEN_WIDTH-1:0] LEN_RESET = 9'd256;

  typedef enum logic [4:0] {
    OP_INVALID = 5'd0,
    OP_LDAV    = 5'd1,
    OP_LDAR    = 5'd2,
    OP_INP     = 5'd3,
    OP_ADD     = 5'd4,
    OP_SUB     = 5'd5,
    OP_MUL     = 5'd6,
    OP_DIV     = 5'd7,
    OP_RADD    = 5'd8,
    OP_RSUB    = 5'd9,
    OP_RMUL    = 5'd10,
    OP_RDIV    = 5'd11,
    OP_STA     = 5'd12,
    OP_BRP     = 5'd13,
    OP_BRPI    = 5'd14,
    OP_BRN     = 5'd15,
    OP_BRNI    = 5'd16,
    OP_BRZ     = 5'd17,
    OP_BRA     = 5'd18,
    OP_BRAA    = 5'd19,
    OP_OUT     = 5'd20,
    OP_OUTL    = 5'd21,
    OP_DRAA    = 5'd22,
    OP_OUTN    = 5'd23,
    OP_PAUS    = 5'd24,
    OP_CLR     = 5'd25,
    OP_HLT     = 5'd26
  } opcode_t;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_NUMBER  = 3'd1,
    EV_CHAR    = 3'd2,
    EV_NEWLINE = 3'd3,
    EV_TEXT    = 3'd4,
    EV_PAUSE   = 3'd5,
    EV_CLEAR   = 3'd6
  } event_t;

  typedef enum logic [2:0] {
    ERR_NONE   = 3'd0,
    ERR_OPCODE = 3'd1,
    ERR_REG    = 3'd2,
    ERR_DIV0   = 3'd3,
    ERR_ADDR   = 3'd4
  } error_t;

endpackage

[src/accumulator_cpu_execute_unit_top.sv]
// Accumulator machine execute unit: one decoded instruction per input beat, one result beat out.
// States run IDLE, READ, EXEC, OUT; DIV/RDIV add DIV (one quotient bit per cycle) and FIX before OUT.
// A new instruction is accepted only in IDLE, so none is taken while one is in flight or its result stalls.
// Depends on accexu_pkg and accumulator_cpu_execute_unit_top_defines.svh.
// Reset (rst, synchronous, active high) clears the accumulator, registers, program counter,
// halt status and sets program_length to 256.
`include "accumulator_cpu_execute_unit_top_defines.svh"

module accumulator_cpu_execute_unit_top #(
  parameter int REGISTER_COUNT = accexu_pkg::REG_COUNT_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // Instruction stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // operand [31:0], input_value [63:32]
  input  logic [4:0]  s_tuser,   // action
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // accumulator_value [31:0], next_address [39:32],
                                 // event_value [71:40], halted [72], error_code [75:73], zero pad
  output logic [2:0]  m_tuser,   // event_kind
  // Configuration: program_length.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_data
);

  localparam int W     = accexu_pkg::DATA_WIDTH;
  localparam int PCW   = accexu_pkg::PC_WIDTH;
  localparam int LENW  = accexu_pkg::LEN_WIDTH;
  localparam int IDXW  = $clog2(REGISTER_COUNT);
  localparam int CNTW  = $clog2(W);

  // The sequencer. READ fetches the register operand, EXEC executes everything but
  // division, DIV runs the restoring divide loop on the shared adder, FIX applies the
  // quotient sign on the same adder, OUT hands the result to the output register.
  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_DIV,
    S_FIX,
    S_OUT
  } state_t;

  state_t state;

  // Latched instruction.
  accexu_pkg::opcode_t op_r;
  logic [W-1:0]        imm_r;
  logic [W-1:0]        inval_r;
  logic [W-1:0]        opnd;
  logic                reg_ok_r;
  logic [IDXW-1:0]     idx_r;

  // Architectural state.
  logic [W-1:0]          acc;
  logic [W-1:0]          regs [REGISTER_COUNT];
  logic [PCW-1:0]        pc;
  logic                  stopped;
  accexu_pkg::error_t    cause;
  logic [LENW-1:0]       prog_len;

  // Divider state.
  logic [W-1:0]  rem;
  logic [W-1:0]  quo;
  logic [W-1:0]  dvs;
  logic          q_neg;
  logic [CNTW-1:0] cnt;

  // Result held between commit and the output register.
  logic [W-1:0]          res_acc;
  logic [PCW-1:0]        res_pc;
  accexu_pkg::event_t    res_ev;
  logic [W-1:0]          res_evv;
  logic                  res_halted;
  accexu_pkg::error_t    res_err;

  // Output register.
  logic [W-1:0]          m_acc;
  logic [PCW-1:0]        m_pc;
  accexu_pkg::event_t    m_ev;
  logic [W-1:0]          m_evv;
  logic                  m_halted;
  accexu_pkg::error_t    m_err;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign m_tdata   = {4'b0, m_err, m_halted, m_evv, m_pc, m_acc};
  assign m_tuser   = m_ev;

  // Register index check on the operand field.
  logic             reg_ok;
  logic [IDXW-1:0]  idx;
  logic             uses_reg;
  assign reg_ok = !imm_r[W-1] && (imm_r[W-2:0] < (W-1)'(REGISTER_COUNT));
  assign idx    = imm_r[IDXW-1:0];
  assign uses_reg = (op_r == accexu_pkg::OP_LDAR) || (op_r == accexu_pkg::OP_RADD) ||
                    (op_r == accexu_pkg::OP_RSUB) || (op_r == accexu_pkg::OP_RMUL) ||
                    (op_r == accexu_pkg::OP_RDIV);

  // Effective program length: program_length capped at the program depth.
  logic [LENW-1:0] limit;
  logic            pc_bad;
  assign limit  = (prog_len < LENW'(accexu_pkg::PROGRAM_DEPTH)) ?
                  prog_len : LENW'(accexu_pkg::PROGRAM_DEPTH);
  assign pc_bad = ({1'b0, pc} >= limit);

  // The shared adder. Operands are W+1 bits so that a divide trial on the shifted
  // remainder fits; bit W+1 of the sum is set exactly when a >= b on a subtraction.
  logic [W:0]   alu_a;
  logic [W:0]   alu_b;
  logic         alu_sub;
  logic [W+1:0] alu_sum;

  always_comb begin
    alu_a   = {1'b0, acc};
    alu_b   = {1'b0, opnd};
    alu_sub = (op_r == accexu_pkg::OP_SUB) || (op_r == accexu_pkg::OP_RSUB);
    case (state)
      S_DIV: begin
        alu_a   = {rem, quo[W-1]};
        alu_b   = {1'b0, dvs};
        alu_sub = 1'b1;
      end
      S_FIX: begin
        alu_a   = '0;
        alu_b   = {1'b0, quo};
        alu_sub = q_neg;
      end
      default: begin
      end
    endcase
  end

  assign alu_sum = {1'b0, alu_a} + {1'b0, alu_b ^ {(W+1){alu_sub}}} + (W+2)'(alu_sub);

  logic [W-1:0] prod;
  assign prod = acc * opnd;

  // Execute decision and the values committed at the end of EXEC or FIX.
  logic [W-1:0]        c_acc;
  logic [PCW-1:0]      c_pc;
  logic                c_stop;
  accexu_pkg::error_t  c_err;
  accexu_pkg::event_t  c_ev;
  logic [W-1:0]        c_evv;
  logic                c_store;
  logic                c_div;
  accexu_pkg::error_t  err;
  logic                halt;
  logic                take;
  logic                acc_neg;
  logic                acc_zero;
  logic [W-1:0]        nxt;

  assign acc_neg  = acc[W-1];
  assign acc_zero = (acc == '0);

  always_comb begin
    c_acc   = acc;
    c_pc    = pc;
    c_stop  = stopped;
    c_err   = cause;
    c_ev    = accexu_pkg::EV_NONE;
    c_evv   = '0;
    c_store = 1'b0;
    c_div   = 1'b0;
    err     = accexu_pkg::ERR_NONE;
    halt    = 1'b0;
    take    = 1'b0;
    nxt     = W'(pc) + W'(1);
    if (!stopped) begin
      if (pc_bad) begin
        err = accexu_pkg::ERR_ADDR;
      end else if (state == S_FIX) begin
        c_acc = alu_sum[W-1:0];
      end else begin
        case (op_r)
          accexu_pkg::OP_LDAV: c_acc = opnd;
          accexu_pkg::OP_INP:  c_acc = inval_r;
          accexu_pkg::OP_ADD,
          accexu_pkg::OP_SUB:  c_acc = alu_sum[W-1:0];
          accexu_pkg::OP_MUL:  c_acc = prod;
          accexu_pkg::OP_LDAR: begin
            if (reg_ok_r) c_acc = opnd;
            else err = accexu_pkg::ERR_REG;
          end
          accexu_pkg::OP_RADD,
          accexu_pkg::OP_RSUB: begin
            if (reg_ok_r) c_acc = alu_sum[W-1:0];
            else err = accexu_pkg::ERR_REG;
          end
          accexu_pkg::OP_RMUL: begin
            if (reg_ok_r) c_acc = prod;
            else err = accexu_pkg::ERR_REG;
          end
          accexu_pkg::OP_DIV,
          accexu_pkg::OP_RDIV: begin
            if (op_r == accexu_pkg::OP_RDIV && !reg_ok_r) err = accexu_pkg::ERR_REG;
            else if (opnd == '0) err = accexu_pkg::ERR_DIV0;
            else c_div = 1'b1;
          end
          accexu_pkg::OP_STA: begin
            if (reg_ok_r) c_store = 1'b1;
            else err = accexu_pkg::ERR_REG;
          end
          accexu_pkg::OP_BRP,
          accexu_pkg::OP_BRPI,
          accexu_pkg::OP_BRN,
          accexu_pkg::OP_BRNI,
          accexu_pkg::OP_BRZ,
          accexu_pkg::OP_BRA: begin
            take = (op_r == accexu_pkg::OP_BRP  && !acc_neg && !acc_zero) ||
                   (op_r == accexu_pkg::OP_BRPI && !acc_neg) ||
                   (op_r == accexu_pkg::OP_BRN  && acc_neg) ||
                   (op_r == accexu_pkg::OP_BRNI && (acc_neg || acc_zero)) ||
                   (op_r == accexu_pkg::OP_BRZ  && acc_zero) ||
                   (op_r == accexu_pkg::OP_BRA);
            if (take) begin
              if (imm_r[W-1]) err = accexu_pkg::ERR_ADDR;
              else nxt = {1'b0, imm_r[W-2:0]};
            end
          end
          accexu_pkg::OP_BRAA: begin
            if (acc_neg) err = accexu_pkg::ERR_ADDR;
            else nxt = acc;
          end
          accexu_pkg::OP_OUT: begin
            c_ev  = accexu_pkg::EV_NUMBER;
            c_evv = acc;
          end
          accexu_pkg::OP_DRAA: begin
            c_ev  = accexu_pkg::EV_CHAR;
            c_evv = acc;
          end
          accexu_pkg::OP_OUTL: c_ev = accexu_pkg::EV_TEXT;
          accexu_pkg::OP_OUTN: c_ev = accexu_pkg::EV_NEWLINE;
          accexu_pkg::OP_PAUS: c_ev = accexu_pkg::EV_PAUSE;
          accexu_pkg::OP_CLR:  c_ev = accexu_pkg::EV_CLEAR;
          accexu_pkg::OP_HLT:  halt = 1'b1;
          default:             err = accexu_pkg::ERR_OPCODE;
        endcase
      end
      // The instruction's effect stands even when the next fetch falls outside the program.
      if (err == accexu_pkg::ERR_NONE && !halt && nxt >= W'(limit)) begin
        err = accexu_pkg::ERR_ADDR;
      end
      if (err != accexu_pkg::ERR_NONE) begin
        c_pc   = '0;
        c_stop = 1'b1;
        c_err  = err;
      end else if (halt) begin
        c_stop = 1'b1;
      end else begin
        c_pc = nxt[PCW-1:0];
      end
    end
  end

  logic commit;
  assign commit = (state == S_FIX) || (state == S_EXEC && !c_div);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      acc      <= '0;
      pc       <= '0;
      stopped  <= 1'b0;
      cause    <= accexu_pkg::ERR_NONE;
      prog_len <= accexu_pkg::LEN_RESET;
      m_tvalid <= 1'b0;
      for (int i = 0; i < REGISTER_COUNT; i++) begin
        regs[i] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        prog_len <= cfg_data;
      end
      // A beat loaded in OUT keeps valid high, so the clear only applies elsewhere.
      if (m_tvalid && m_tready && state != S_OUT) begin
        m_tvalid <= 1'b0;
      end
      if (commit) begin
        acc        <= c_acc;
        pc         <= c_pc;
        stopped    <= c_stop;
        cause      <= c_err;
        res_acc    <= c_acc;
        res_pc     <= c_pc;
        res_ev     <= c_ev;
        res_evv    <= c_evv;
        res_halted <= c_stop;
        res_err    <= c_err;
        if (c_store) begin
          regs[idx_r] <= acc;
        end
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op_r    <= accexu_pkg::opcode_t'(s_tuser);
            imm_r   <= s_tdata[W-1:0];
            inval_r <= s_tdata[2*W-1:W];
            state   <= S_READ;
          end
        end
        S_READ: begin
          reg_ok_r <= reg_ok;
          idx_r    <= idx;
          if (uses_reg) opnd <= reg_ok ? regs[idx] : '0;
          else opnd <= imm_r;
          state <= S_EXEC;
        end
        S_EXEC: begin
          if (c_div) begin
            rem   <= '0;
            quo   <= acc_neg ? (W'(0) - acc) : acc;
            dvs   <= opnd[W-1] ? (W'(0) - opnd) : opnd;
            q_neg <= acc_neg ^ opnd[W-1];
            cnt   <= CNTW'(W - 1);
            state <= S_DIV;
          end else begin
            state <= S_OUT;
          end
        end
        S_DIV: begin
          // One quotient bit per cycle: keep the trial difference when it did not borrow.
          if (alu_sum[W+1]) rem <= alu_sum[W-1:0];
          else rem <= {rem[W-2:0], quo[W-1]};
          quo <= {quo[W-2:0], alu_sum[W+1]};
          if (cnt == '0) state <= S_FIX;
          else cnt <= cnt - CNTW'(1);
        end
        S_FIX: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_acc    <= res_acc;
            m_pc     <= res_pc;
            m_ev     <= res_ev;
            m_evv    <= res_evv;
            m_halted <= res_halted;
            m_err    <= res_err;
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Once stopped, only reset restarts the machine.
  `ACCEXU_ASSERT(a_stop_sticky, stopped |=> stopped, "stopped cleared without reset")
  // An error halt always parks the program counter at zero with the machine stopped.
  `ACCEXU_ASSERT_NEVER(a_err_park, (cause != accexu_pkg::ERR_NONE) && (pc != '0 || !stopped), "error without halt at address zero")
  // The divide loop runs its full count before the sign fix.
  `ACCEXU_ASSERT(a_div_count, (state == S_DIV) && (cnt != '0) |=> (state == S_DIV), "divide loop left early")

endmodule

[tb/testbench.sv]
// Self-checking testbench for accumulator_cpu_execute_unit_top, the accumulator machine execute unit.
// Streams decoded instructions and program_length writes, predicts every result beat with a
// model of the machine kept here, and depends only on accexu_pkg and the block's RTL.
module testbench;
  import accexu_pkg::*;

  localparam int REG_COUNT = REG_COUNT_DEFAULT;
  localparam logic [4:0] OPCODE_MAX = 5'h1f;
  // Receiver hold-off length, long enough to fill every stage of the block.
  localparam int LONG_HOLD = 300;
  // Long enough for any beat still in flight, a divide included.
  localparam int DRAIN_WAIT = 40;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [31:0] acc;
    logic [7:0]  next_addr;
    event_t      ev_kind;
    logic [31:0] ev_value;
    logic        halted;
    error_t      err;
  } exec_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;   // operand [31:0], input_value [63:32]
  logic [4:0]  s_tuser = '0;   // action
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;        // accumulator_value [31:0], next_address [39:32],
                               // event_value [71:40], halted [72], error_code [75:73]
  logic [2:0]  m_tuser;        // event_kind
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [8:0]  cfg_data = '0;

  // Machine state as the testbench expects it to be after every accepted instruction.
  logic [31:0] model_acc = '0;
  logic [31:0] model_regs [REG_COUNT] = '{default: '0};
  logic [7:0]  model_pc = '0;
  logic        model_stopped = 1'b0;
  error_t      model_err = ERR_NONE;
  logic [8:0]  model_len = LEN_RESET;

  // Results predicted for accepted instructions, oldest first.
  exec_result_t pending_results [$];

  int    fail_count = 0;
  int    sent_count = 0;
  int    checked_count = 0;
  int    length_writes = 0;
  int    cycle_count = 0;
  string halt_case = "none";
  logic  no_idle = 1'b0;
  // Hold-off requests from the stimulus side and the ones the receiver has served.
  int    hold_off_req = 0;
  int    hold_off_done = 0;

  accumulator_cpu_execute_unit_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------------------------
  // Model of the machine.
  // ---------------------------------------------------------------------------------------------

  // Fetches are legal below program_length, but never beyond the program store.
  function automatic logic [31:0] fetch_limit();
    return (model_len < PROGRAM_DEPTH) ? 32'(model_len) : 32'(PROGRAM_DEPTH);
  endfunction

  // Branch decision on the accumulator; false for every opcode that is not a branch.
  function automatic logic branch_taken(input logic [4:0] act, input logic [31:0] acc);
    logic neg;
    logic zero;
    neg  = acc[31];
    zero = (acc == '0);
    case (act)
      OP_BRP:  return !neg && !zero;
      OP_BRPI: return !neg;
      OP_BRN:  return neg;
      OP_BRNI: return neg || zero;
      OP_BRZ:  return zero;
      OP_BRA:  return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // Truncating signed divide. The most negative value over minus one wraps back onto itself.
  function automatic logic [31:0] signed_quotient(input logic [31:0] num, input logic [31:0] den);
    logic [31:0] num_mag;
    logic [31:0] den_mag;
    logic [31:0] quo;
    num_mag = num[31] ? -num : num;
    den_mag = den[31] ? -den : den;
    quo = num_mag / den_mag;
    return (num[31] != den[31]) ? -quo : quo;
  endfunction

  // Executes one instruction on the model state and returns the result beat it must produce.
  function automatic exec_result_t execute_instruction(input logic [4:0] act,
                                                       input logic [31:0] opnd,
                                                       input logic [31:0] inval);
    exec_result_t res;
    logic [31:0]  lim;
    logic [31:0]  nxt;
    logic [31:0]  rv;
    logic         reg_ok;
    logic         halt;
    error_t       e;
    res.ev_kind  = EV_NONE;
    res.ev_value = '0;
    e    = ERR_NONE;
    halt = 1'b0;
    lim  = fetch_limit();
    // A stopped machine only echoes its state, so nothing below runs.
    if (!model_stopped) begin
      if (32'(model_pc) >= lim) begin
        // The length was lowered under the program counter: nothing executes.
        model_pc      = '0;
        model_stopped = 1'b1;
        model_err     = ERR_ADDR;
      end else begin
        nxt    = 32'(model_pc) + 32'd1;
        // A negative index is huge as an unsigned number, so one compare covers both sides.
        reg_ok = (opnd < REG_COUNT);
        rv     = reg_ok ? model_regs[opnd] : '0;
        case (act)
          OP_LDAV: model_acc = opnd;
          OP_LDAR: if (reg_ok) model_acc = rv; else e = ERR_REG;
          OP_INP:  model_acc = inval;
          OP_ADD:  model_acc = model_acc + opnd;
          OP_SUB:  model_acc = model_acc - opnd;
          OP_MUL:  model_acc = model_acc * opnd;
          OP_DIV: begin
            if (opnd == '0) e = ERR_DIV0;
            else model_acc = signed_quotient(model_acc, opnd);
          end
          OP_RADD: if (reg_ok) model_acc = model_acc + rv; else e = ERR_REG;
          OP_RSUB: if (reg_ok) model_acc = model_acc - rv; else e = ERR_REG;
          OP_RMUL: if (reg_ok) model_acc = model_acc * rv; else e = ERR_REG;
          OP_RDIV: begin
            if (!reg_ok) e = ERR_REG;
            else if (rv == '0) e = ERR_DIV0;
            else model_acc = signed_quotient(model_acc, rv);
          end
          OP_STA: if (reg_ok) model_regs[opnd] = model_acc; else e = ERR_REG;
          OP_BRP, OP_BRPI, OP_BRN, OP_BRNI, OP_BRZ, OP_BRA: begin
            if (branch_taken(act, model_acc)) begin
              if (opnd[31]) e = ERR_ADDR;
              else nxt = opnd;
            end
          end
          OP_BRAA: if (model_acc[31]) e = ERR_ADDR; else nxt = model_acc;
          OP_OUT: begin
            res.ev_kind  = EV_NUMBER;
            res.ev_value = model_acc;
          end
          OP_OUTL: res.ev_kind = EV_TEXT;
          OP_DRAA: begin
            res.ev_kind  = EV_CHAR;
            res.ev_value = model_acc;
          end
          OP_OUTN: res.ev_kind = EV_NEWLINE;
          OP_PAUS: res.ev_kind = EV_PAUSE;
          OP_CLR:  res.ev_kind = EV_CLEAR;
          OP_HLT:  halt = 1'b1;
          default: e = ERR_OPCODE;
        endcase
        // The instruction's own effect stands even when the following fetch is illegal.
        if (e == ERR_NONE && !halt && nxt >= lim) e = ERR_ADDR;
        if (e != ERR_NONE) begin
          model_pc      = '0;
          model_stopped = 1'b1;
          model_err     = e;
        end else if (halt) begin
          model_stopped = 1'b1;
        end else begin
          model_pc = nxt[7:0];
        end
      end
    end
    res.acc       = model_acc;
    res.next_addr = model_pc;
    res.halted    = model_stopped;
    res.err       = model_err;
    return res;
  endfunction

  // ---------------------------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------------------------

  // Operand values: small numbers keep branches and BRAA in range, extremes hit the wrap cases.
  function automatic logic [31:0] random_word();
    case ($urandom_range(0, 7))
      0, 1: return $urandom_range(0, 16) - 8;
      2: begin
        case ($urandom_range(0, 3))
          0:       return 32'h8000_0000;
          1:       return 32'h7fff_ffff;
          2:       return 32'hffff_ffff;
          default: return 32'h0000_0000;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  // Builds a random instruction that keeps the machine running, judged from the model state.
  task automatic pick_safe_instruction(output logic [4:0] act, output logic [31:0] opnd,
                                       output logic [31:0] inval);
    logic [31:0] lim;
    logic        jumps;
    lim   = fetch_limit();
    act   = 5'($urandom_range(OP_LDAV, OP_CLR));
    opnd  = random_word();
    inval = random_word();
    case (act)
      OP_LDAR, OP_RADD, OP_RSUB, OP_RMUL, OP_STA: opnd = $urandom_range(0, REG_COUNT - 1);
      OP_RDIV: begin
        opnd = $urandom_range(0, REG_COUNT - 1);
        if (model_regs[opnd] == '0) act = OP_RADD;
      end
      OP_DIV: if (opnd == '0) opnd = $urandom_range(1, 1000);
      OP_BRAA: begin
        if (model_acc[31] || model_acc >= lim) begin
          act  = OP_BRA;
          opnd = $urandom_range(0, lim - 1);
        end
      end
      default: begin
        // A taken branch needs a legal target; an untaken one keeps its random operand.
        if (branch_taken(act, model_acc)) opnd = $urandom_range(0, lim - 1);
      end
    endcase
    jumps = (act == OP_BRAA) || branch_taken(act, model_acc);
    // At the last legal address only a jump keeps the program alive.
    if (!jumps && 32'(model_pc) + 32'd1 >= lim) begin
      act  = OP_BRA;
      opnd = $urandom_range(0, lim - 1);
    end
  endtask

  // Offers one instruction beat and returns at the falling edge after it was taken. Valid
  // stays high into the next call, so back-to-back beats need no gap.
  task automatic send_instruction(input logic [4:0] act, input logic [31:0] opnd,
                                  input logic [31:0] inval);
    if (!no_idle && $urandom_range(0, 99) < 6) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    s_tuser  <= act;
    s_tdata  <= {inval, opnd};
    s_tvalid <= 1'b1;
    pending_results.push_back(execute_instruction(act, opnd, inval));
    sent_count++;
    do @(posedge clk); while (s_tready !== 1'b1);
    @(negedge clk);
  endtask

  task automatic run_random(input int count);
    logic [4:0]  act;
    logic [31:0] opnd;
    logic [31:0] inval;
    repeat (count) begin
      pick_safe_instruction(act, opnd, inval);
      send_instruction(act, opnd, inval);
    end
  endtask

  // Moves the program counter to 0, which is legal under any nonzero length.
  task automatic park_program_counter();
    send_instruction(OP_BRA, '0, random_word());
  endtask

  // program_length changes only while the block is idle: every result beat has come back.
  task automatic write_program_length(input logic [8:0] len);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    cfg_data  <= len;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
    cfg_valid <= 1'b0;
    model_len = len;
    length_writes++;
  endtask

  // ---------------------------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------------------------

  // Every operation but BRA and HLT, overflow wrap both ways, divide rounding and the most negative value
  // divided by minus one, the highest register index and the branches at the program's end.
  task automatic test_directed_ops();
    send_instruction(OP_LDAV, 32'h7fff_ffff, random_word());
    send_instruction(OP_ADD,  32'h0000_0001, random_word());
    send_instruction(OP_SUB,  32'h0000_0001, random_word());
    send_instruction(OP_MUL,  32'h7fff_ffff, random_word());
    send_instruction(OP_INP,  random_word(), 32'h8000_0000);
    send_instruction(OP_STA,  REG_COUNT - 1, random_word());
    send_instruction(OP_DIV,  32'hffff_ffff, random_word());
    send_instruction(OP_LDAV, 32'hffff_ffff, random_word());
    send_instruction(OP_STA,  32'h0000_0000, random_word());
    send_instruction(OP_LDAR, REG_COUNT - 1, random_word());
    send_instruction(OP_RDIV, 32'h0000_0000, random_word());
    send_instruction(OP_RMUL, 32'h0000_0000, random_word());
    send_instruction(OP_RSUB, 32'h0000_0000, random_word());
    send_instruction(OP_RADD, REG_COUNT - 1, random_word());
    send_instruction(OP_LDAV, 32'h0000_0007, random_word());
    send_instruction(OP_DIV,  32'hffff_fffe, random_word());
    send_instruction(OP_OUT,  random_word(), random_word());
    send_instruction(OP_DRAA, random_word(), random_word());
    send_instruction(OP_OUTL, random_word(), random_word());
    send_instruction(OP_OUTN, random_word(), random_word());
    send_instruction(OP_PAUS, random_word(), random_word());
    send_instruction(OP_CLR,  random_word(), random_word());
    send_instruction(OP_BRN,  32'd200, random_word());
    send_instruction(OP_LDAV, 32'h0000_0000, random_word());
    send_instruction(OP_BRZ,  PROGRAM_DEPTH - 1, random_word());
    // From the last address only a taken branch is legal.
    send_instruction(OP_BRPI, 32'd10, random_word());
    // An untaken branch ignores its target, even a negative one.
    send_instruction(OP_BRP,  32'h8000_0000, random_word());
    send_instruction(OP_BRNI, 32'd40, random_word());
    send_instruction(OP_LDAV, 32'd100, random_word());
    send_instruction(OP_BRAA, random_word(), random_word());
  endtask

  // Runs short programs under the smallest and largest lengths, values past the program store
  // and one random length.
  task automatic test_length_settings();
    logic [8:0] lengths [6] = '{9'd1, 9'd2, 9'd511, 9'd300, 9'd0, 9'd256};
    lengths[4] = 9'($urandom_range(3, 255));
    foreach (lengths[i]) begin
      park_program_counter();
      write_program_length(lengths[i]);
      run_random(30);
    end
  endtask

  // Both sides keep their valid and ready high for a whole stretch.
  task automatic test_burst();
    no_idle <= 1'b1;
    run_random(120);
    no_idle <= 1'b0;
  endtask

  // The receiver holds off for a long stretch while instructions keep coming, so the block
  // fills up and must stall its input.
  task automatic test_backpressure();
    hold_off_req <= hold_off_req + 1;
    run_random(80);
  endtask

  // Long random programs, mostly at the full length.
  task automatic test_random_program();
    repeat (4) begin
      park_program_counter();
      write_program_length(($urandom_range(0, 3) == 0) ? 9'($urandom_range(2, 511)) : LEN_RESET);
      run_random(150);
    end
  endtask

  // A halt is sticky until reset and reset comes only once, so the run ends on one halt cause
  // that the seed picks, then checks that a stopped machine only echoes its state.
  task automatic test_final_halt();
    logic [4:0]  reg_ops [6] = '{OP_LDAR, OP_RADD, OP_RSUB, OP_RMUL, OP_RDIV, OP_STA};
    logic [31:0] lim;
    logic [31:0] target;
    logic [4:0]  act;
    park_program_counter();
    write_program_length(9'($urandom_range(4, 511)));
    lim = fetch_limit();
    case ($urandom_range(0, 5))
      0: begin
        halt_case = "invalid opcode";
        act = ($urandom_range(0, 3) == 0) ? OP_INVALID
                                          : 5'($urandom_range(OP_HLT + 1, OPCODE_MAX));
        send_instruction(act, random_word(), random_word());
      end
      1: begin
        halt_case = "register index out of range";
        target = ($urandom_range(0, 1) == 0) ? ($urandom() | 32'h8000_0000)
                                             : $urandom_range(REG_COUNT, 32'h7fff_ffff);
        send_instruction(reg_ops[$urandom_range(0, 5)], target, random_word());
      end
      2: begin
        halt_case = "divide by zero";
        if ($urandom_range(0, 1) == 0) begin
          send_instruction(OP_DIV, '0, random_word());
        end else begin
          target = $urandom_range(0, REG_COUNT - 1);
          send_instruction(OP_LDAV, '0, random_word());
          send_instruction(OP_STA, target, random_word());
          send_instruction(OP_LDAV, random_word(), random_word());
          send_instruction(OP_RDIV, target, random_word());
        end
      end
      3: begin
        halt_case = "fetch out of range";
        case ($urandom_range(0, 3))
          0: begin
            // The add itself still lands in the accumulator.
            send_instruction(OP_BRA, lim - 1, random_word());
            send_instruction(OP_ADD, random_word(), random_word());
          end
          1: send_instruction(OP_BRA, $urandom() | 32'h8000_0000, random_word());
          2: send_instruction(OP_BRA, ($urandom_range(0, 3) == 0) ? 32'h7fff_ffff
                                      : lim + $urandom_range(0, 1000), random_word());
          default: begin
            send_instruction(OP_LDAV, $urandom() | 32'h8000_0000, random_word());
            send_instruction(OP_BRAA, random_word(), random_word());
          end
        endcase
      end
      4: begin
        halt_case = "program counter beyond a lowered length";
        target = $urandom_range(1, lim - 1);
        send_instruction(OP_BRA, target, random_word());
        write_program_length(($urandom_range(0, 1) == 0) ? 9'd0 : 9'($urandom_range(1, target)));
        send_instruction(5'($urandom_range(0, OPCODE_MAX)), random_word(), random_word());
      end
      default: begin
        halt_case = "halt instruction";
        send_instruction(OP_HLT, random_word(), random_word());
      end
    endcase
    repeat (8) send_instruction(5'($urandom_range(0, OPCODE_MAX)), random_word(), random_word());
  endtask

  // ---------------------------------------------------------------------------------------------
  // Result side.
  // ---------------------------------------------------------------------------------------------

  // Result ready: random idling, none during the burst, and the long hold-off on request.
  always begin
    @(negedge clk);
    if (hold_off_req != hold_off_done) begin
      m_tready <= 1'b0;
      repeat (LONG_HOLD) @(negedge clk);
      hold_off_done <= hold_off_req;
    end else begin
      m_tready <= no_idle || ($urandom_range(0, 99) >= 6);
    end
  end

  // Every accepted result beat is compared field by field with the oldest prediction.
  always @(posedge clk) begin
    exec_result_t want;
    if (!rst && m_tvalid === 1'b1 && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no instruction outstanding: tdata %h", m_tdata);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        checked_count++;
        if (m_tdata[31:0] !== want.acc) begin
          $error("accumulator_value: expected %h, actual %h", want.acc, m_tdata[31:0]);
          fail_count++;
        end
        if (m_tdata[39:32] !== want.next_addr) begin
          $error("next_address: expected %0d, actual %0d", want.next_addr, m_tdata[39:32]);
          fail_count++;
        end
        if (m_tuser !== want.ev_kind) begin
          $error("event_kind: expected %0d, actual %0d", want.ev_kind, m_tuser);
          fail_count++;
        end
        if (m_tdata[71:40] !== want.ev_value) begin
          $error("event_value: expected %h, actual %h", want.ev_value, m_tdata[71:40]);
          fail_count++;
        end
        if (m_tdata[72] !== want.halted) begin
          $error("halted: expected %0d, actual %0d", want.halted, m_tdata[72]);
          fail_count++;
        end
        if (m_tdata[75:73] !== want.err) begin
          $error("error_code: expected %0d, actual %0d", want.err, m_tdata[75:73]);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count,
               pending_results.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed_ops();
    test_length_settings();
    test_burst();
    test_backpressure();
    test_random_program();
    test_final_halt();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    // Anything the block still emits now has no prediction and is flagged by the checker.
    repeat (DRAIN_WAIT) @(negedge clk);
    $display("Checked %0d result beats from %0d instructions over %0d program_length writes.",
             checked_count, sent_count, length_writes);
    $display("Directed, random, burst and back-pressure phases ran; final halt cause: %s.",
             halt_case);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
